// File: hdl/arpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_pkg: shared types, constants and frame builder for the ARP core
// Holds the command format passed from front to back, ARP frame offsets
// and the byte-by-byte builder of outgoing 60-byte ARP frames.
// ----------------------------------------------------------------------------
package arpc_pkg;

  // Frame geometry
  localparam int FRAME_CAPTURE = 42;
  localparam int FRAME_OUT     = 60;
  localparam int POS_OP        = 21;
  localparam int POS_SND_MAC   = 22;
  localparam int POS_SND_IP    = 28;
  localparam int POS_TGT_IP    = 38;

  // ARP field values
  localparam logic [7:0]  ARP_OP_REQUEST = 8'h01;
  localparam logic [7:0]  ARP_OP_REPLY   = 8'h02;
  localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
  localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
  localparam logic [15:0] ARP_PTYPE_IP   = 16'h0800;
  localparam logic [7:0]  ARP_HLEN       = 8'h06;
  localparam logic [7:0]  ARP_PLEN       = 8'h04;
  localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;

  // Input request codes
  localparam logic OPC_RX_BYTE = 1'b0;
  localparam logic OPC_RESOLVE = 1'b1;

  // Result kinds
  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  // Configuration register indexes
  localparam logic CFG_OWN_MAC = 1'b0;
  localparam logic CFG_OWN_IP  = 1'b1;

  // Command queue depth
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REPLY  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] ip;
    logic [47:0] mac;
  } cmd_t;

  function automatic logic [7:0] mac_byte(logic [47:0] mac, logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      3'd5:    b = mac[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ip_byte(logic [31:0] ip, logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = ip[31:24];
      2'd1:    b = ip[23:16];
      2'd2:    b = ip[15:8];
      default: b = ip[7:0];
    endcase
    return b;
  endfunction

  // One byte of an outgoing ARP frame; sender MAC is always own_mac and
  // the target MAC repeats the destination MAC.
  function automatic logic [7:0] frame_byte(logic [5:0] idx, logic [47:0] dst,
                                            logic [47:0] own_mac,
                                            logic [31:0] snd_ip,
                                            logic [31:0] tgt_ip,
                                            logic [7:0] op);
    logic [7:0] b;
    case (idx) inside
      [6'd0:6'd5]:   b = mac_byte(dst, 3'(idx));
      [6'd6:6'd11]:  b = mac_byte(own_mac, 3'(idx - 6'd6));
      6'd12:         b = ETH_TYPE_ARP[15:8];
      6'd13:         b = ETH_TYPE_ARP[7:0];
      6'd14:         b = ARP_HTYPE_ETH[15:8];
      6'd15:         b = ARP_HTYPE_ETH[7:0];
      6'd16:         b = ARP_PTYPE_IP[15:8];
      6'd17:         b = ARP_PTYPE_IP[7:0];
      6'd18:         b = ARP_HLEN;
      6'd19:         b = ARP_PLEN;
      6'd21:         b = op;
      [6'd22:6'd27]: b = mac_byte(own_mac, 3'(idx - 6'd22));
      [6'd28:6'd31]: b = ip_byte(snd_ip, 2'(idx - 6'd28));
      [6'd32:6'd37]: b = mac_byte(dst, 3'(idx - 6'd32));
      [6'd38:6'd41]: b = ip_byte(tgt_ip, 2'(idx - 6'd38));
      default:       b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: hdl/arp_responder_and_cache_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arp_responder_and_cache_core: ARP responder with address cache
// Answers ARP requests for the own IP, learns senders of ARP replies and
// resolves IP addresses against the cache, broadcasting a request on a miss.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake; opcode 0 carries one received frame
//           byte (rx_last on the final byte), opcode 1 resolves query_ip.
//   out_* : kind 0 is one byte of an outgoing 60-byte frame (tx_last on the
//           last byte), kind 1 is a lookup answer with hit and found_mac.
//   cfg_* : index 0 writes own_mac, index 1 writes own_ip[31:0] of cfg_data;
//           always ready; write only while the core is quiet.
// Throughput: frame bytes are taken one per cycle. A frame that triggers
//   work and every lookup become commands in a two-entry queue; the front
//   stalls only while that queue is full.
// Order: a lookup scans the cache one entry per cycle through its single
//   read port; its answer is registered after the scan and a drain step,
//   once the result register is free, and an insert is written after the
//   same scan and drain. A transmitted frame streams 60 bytes, one per
//   cycle while out_ready holds.
// Stall: when out_ready is low the result register holds and the back end
//   waits; the front keeps taking bytes until the queue fills.
// Reset: rst_n low empties the cache, queue and byte counter and clears
//   own_mac and own_ip; no clearing pass is needed.
// ----------------------------------------------------------------------------
module arp_responder_and_cache_core import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_last,
  input  logic [31:0] in_query_ip,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic        out_hit,
  output logic [47:0] out_found_mac
);

  logic [47:0] own_mac_r, own_mac_nxt;
  logic [31:0] own_ip_r, own_ip_nxt;

  logic fe_cmd_valid;
  logic fe_cmd_ready;
  cmd_t fe_cmd;
  logic be_cmd_valid;
  logic be_cmd_ready;
  cmd_t be_cmd;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    own_mac_nxt = own_mac_r;
    own_ip_nxt  = own_ip_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OWN_MAC: own_mac_nxt = cfg_data;
        CFG_OWN_IP:  own_ip_nxt  = cfg_data[31:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
    end else begin
      own_mac_r <= own_mac_nxt;
      own_ip_r  <= own_ip_nxt;
    end
  end

  // Front: capture frame fields, classify frames and lookups
  arpc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .own_ip      (own_ip_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_rx_byte  (in_rx_byte),
    .in_rx_last  (in_rx_last),
    .in_query_ip (in_query_ip),
    .cmd_valid   (fe_cmd_valid),
    .cmd         (fe_cmd),
    .cmd_ready   (fe_cmd_ready)
  );

  // Queue: lets the front keep taking bytes while the back end is busy
  arpc_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_cmd_valid),
    .push_ready (fe_cmd_ready),
    .push_data  (fe_cmd),
    .pop_valid  (be_cmd_valid),
    .pop_ready  (be_cmd_ready),
    .pop_data   (be_cmd)
  );

  // Back: cache search, insertion and frame transmission
  arpc_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .own_mac       (own_mac_r),
    .own_ip        (own_ip_r),
    .cmd_valid     (be_cmd_valid),
    .cmd_ready     (be_cmd_ready),
    .cmd           (be_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_tx_byte   (out_tx_byte),
    .out_tx_last   (out_tx_last),
    .out_hit       (out_hit),
    .out_found_mac (out_found_mac)
  );

  // A taken miss answer is followed at once by the first request byte
  a_miss_then_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_kind == KIND_ANSWER) && !out_hit
    |=> out_valid && (out_kind == KIND_FRAME))
    else $error("miss answer not followed by request frame");

  // Frame bytes stream without gaps until the last byte
  a_frame_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_kind == KIND_FRAME) && !out_tx_last
    |=> out_valid && (out_kind == KIND_FRAME))
    else $error("outgoing frame interrupted");

  // The last byte flag belongs to frame bytes only
  a_last_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_last |-> (out_kind == KIND_FRAME) && !out_hit)
    else $error("tx_last on a lookup answer");

endmodule
`default_nettype wire

// File: hdl/arpc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_front: request intake and frame classifier
// Captures the ARP fields of received frames and turns frames and lookups
// into commands for the back end.
// ----------------------------------------------------------------------------
module arpc_front import arpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] own_ip,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_last,
  input  logic [31:0] in_query_ip,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_ready
);

  logic [5:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [47:0] snd_mac_r, snd_mac_nxt;
  logic [31:0] snd_ip_r, snd_ip_nxt;
  logic [31:0] tgt_ip_r, tgt_ip_nxt;
  logic        accept;
  logic        is_byte;
  logic        capturing;
  logic        frame_ok;

  assign in_ready  = cmd_ready;
  assign accept    = in_valid && in_ready;
  assign is_byte   = (in_opcode == OPC_RX_BYTE);
  assign capturing = (byte_count_r < 6'(FRAME_CAPTURE));
  assign frame_ok  = in_rx_last && (byte_count_r >= 6'(FRAME_CAPTURE - 1));

  // Field values with the current byte merged in
  always_comb begin
    op_nxt      = op_r;
    snd_mac_nxt = snd_mac_r;
    snd_ip_nxt  = snd_ip_r;
    tgt_ip_nxt  = tgt_ip_r;
    if (capturing) begin
      if (byte_count_r == 6'(POS_OP)) begin
        op_nxt = in_rx_byte;
      end
      for (int i = 0; i < 6; i++) begin
        if (byte_count_r == 6'(POS_SND_MAC + i)) begin
          snd_mac_nxt[47 - 8 * i -: 8] = in_rx_byte;
        end
      end
      for (int i = 0; i < 4; i++) begin
        if (byte_count_r == 6'(POS_SND_IP + i)) begin
          snd_ip_nxt[31 - 8 * i -: 8] = in_rx_byte;
        end
        if (byte_count_r == 6'(POS_TGT_IP + i)) begin
          tgt_ip_nxt[31 - 8 * i -: 8] = in_rx_byte;
        end
      end
    end
  end

  // Classify
  always_comb begin
    cmd_valid = 1'b0;
    cmd       = '{kind: CMD_LOOKUP, ip: in_query_ip, mac: '0};
    if (is_byte) begin
      if (frame_ok && (op_nxt == ARP_OP_REQUEST) && (tgt_ip_nxt == own_ip)) begin
        cmd_valid = in_valid;
        cmd       = '{kind: CMD_REPLY, ip: snd_ip_nxt, mac: snd_mac_nxt};
      end else if (frame_ok && (op_nxt == ARP_OP_REPLY)) begin
        cmd_valid = in_valid;
        cmd       = '{kind: CMD_INSERT, ip: snd_ip_nxt, mac: snd_mac_nxt};
      end
    end else begin
      cmd_valid = in_valid;
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    if (accept && is_byte) begin
      if (in_rx_last) begin
        byte_count_nxt = '0;
      end else if (capturing) begin
        byte_count_nxt = byte_count_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_byte) begin
      op_r      <= op_nxt;
      snd_mac_r <= snd_mac_nxt;
      snd_ip_r  <= snd_ip_nxt;
      tgt_ip_r  <= tgt_ip_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/arpc_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_cmd_fifo: short command queue between front and back
// Decouples frame intake from cache search and frame transmission.
// ----------------------------------------------------------------------------
module arpc_cmd_fifo import arpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMDQ_DEPTH - 1);

  cmd_t             slot_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(CMDQ_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: hdl/arpc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_back: cache search, insertion and frame transmitter
// Scans the address cache one entry per cycle, inserts learned entries and
// drives the registered result stage.
// ----------------------------------------------------------------------------
module arpc_back import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [47:0] own_mac,
  input  logic [31:0] own_ip,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic        out_hit,
  output logic [47:0] out_found_mac
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_DECIDE = 5'b01000,
    S_TX     = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  logic [IDX_W-1:0]         scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]         ptr_r, ptr_nxt;
  logic [CACHE_ENTRIES-1:0] vld_r;
  logic [31:0]              entry_ip_mem  [CACHE_ENTRIES];
  logic [47:0]              entry_mac_mem [CACHE_ENTRIES];
  logic                     rd_live_r;
  logic                     rd_vld_r;
  logic [31:0]              rd_ip_r;
  logic [47:0]              rd_mac_r;
  logic                     hit_r, hit_nxt;
  logic [47:0]              hit_mac_r, hit_mac_nxt;
  logic [5:0]               tx_idx_r, tx_idx_nxt;
  logic                     ins_we;
  logic                     match;
  logic                     slot_free;
  logic [47:0]              tx_dst;
  logic [7:0]               tx_op;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  out_tx_byte_r, out_tx_byte_nxt;
  logic        out_tx_last_r, out_tx_last_nxt;
  logic        out_hit_r, out_hit_nxt;
  logic [47:0] out_found_mac_r, out_found_mac_nxt;
  logic        out_load;

  assign cmd_ready = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign match     = rd_live_r && rd_vld_r && (rd_ip_r == cmd_r.ip);
  assign tx_dst    = (cmd_r.kind == CMD_REPLY) ? cmd_r.mac : MAC_BCAST;
  assign tx_op     = (cmd_r.kind == CMD_REPLY) ? ARP_OP_REPLY : ARP_OP_REQUEST;

  always_comb begin
    state_nxt         = state_r;
    cmd_nxt           = cmd_r;
    scan_idx_nxt      = scan_idx_r;
    ptr_nxt           = ptr_r;
    hit_nxt           = hit_r;
    hit_mac_nxt       = hit_mac_r;
    tx_idx_nxt        = tx_idx_r;
    ins_we            = 1'b0;
    out_load          = 1'b0;
    out_kind_nxt      = out_kind_r;
    out_tx_byte_nxt   = out_tx_byte_r;
    out_tx_last_nxt   = out_tx_last_r;
    out_hit_nxt       = out_hit_r;
    out_found_mac_nxt = out_found_mac_r;

    // Keep the first matching entry
    if (match && !hit_r) begin
      hit_nxt     = 1'b1;
      hit_mac_nxt = rd_mac_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt      = cmd;
          hit_nxt      = 1'b0;
          scan_idx_nxt = '0;
          tx_idx_nxt   = '0;
          state_nxt    = (cmd.kind == CMD_REPLY) ? S_TX : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx_r == IDX_LAST) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (cmd_r.kind == CMD_INSERT) begin
          if (!hit_r) begin
            ins_we  = 1'b1;
            ptr_nxt = (ptr_r == IDX_LAST) ? '0 : ptr_r + IDX_W'(1);
          end
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_load          = 1'b1;
          out_kind_nxt      = KIND_ANSWER;
          out_tx_byte_nxt   = 8'h00;
          out_tx_last_nxt   = 1'b0;
          out_hit_nxt       = hit_r;
          out_found_mac_nxt = hit_r ? hit_mac_r : '0;
          state_nxt         = hit_r ? S_IDLE : S_TX;
        end
      end
      S_TX: begin
        if (slot_free) begin
          out_load          = 1'b1;
          out_kind_nxt      = KIND_FRAME;
          out_tx_byte_nxt   = frame_byte(tx_idx_r, tx_dst, own_mac, own_ip,
                                         cmd_r.ip, tx_op);
          out_tx_last_nxt   = (tx_idx_r == 6'(FRAME_OUT - 1));
          out_hit_nxt       = 1'b0;
          out_found_mac_nxt = '0;
          if (tx_idx_r == 6'(FRAME_OUT - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            tx_idx_nxt = tx_idx_r + 6'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      vld_r       <= '0;
      rd_live_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      rd_live_r   <= (state_r == S_SCAN);
      out_valid_r <= out_valid_nxt;
      if (ins_we) begin
        vld_r[ptr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r           <= cmd_nxt;
    scan_idx_r      <= scan_idx_nxt;
    hit_r           <= hit_nxt;
    hit_mac_r       <= hit_mac_nxt;
    tx_idx_r        <= tx_idx_nxt;
    rd_vld_r        <= vld_r[scan_idx_r];
    out_kind_r      <= out_kind_nxt;
    out_tx_byte_r   <= out_tx_byte_nxt;
    out_tx_last_r   <= out_tx_last_nxt;
    out_hit_r       <= out_hit_nxt;
    out_found_mac_r <= out_found_mac_nxt;
  end

  // Cache storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ins_we) begin
      entry_ip_mem[ptr_r]  <= cmd_r.ip;
      entry_mac_mem[ptr_r] <= cmd_r.mac;
    end
    rd_ip_r  <= entry_ip_mem[scan_idx_r];
    rd_mac_r <= entry_mac_mem[scan_idx_r];
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_tx_byte   = out_tx_byte_r;
  assign out_tx_last   = out_tx_last_r;
  assign out_hit       = out_hit_r;
  assign out_found_mac = out_found_mac_r;

endmodule
`default_nettype wire
